/* rtl/core/lpf_pkg.sv */
// Package for the DSI low-power packet framer: command struct, codes,
// framing constants and the bit-reverse, header ECC and CRC-16 functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpf_pkg;

   localparam logic [1:0] FUNC_SHORT   = 2'd0;
   localparam logic [1:0] FUNC_LONG    = 2'd1;
   localparam logic [1:0] FUNC_PAYLOAD = 2'd2;

   localparam logic [1:0] KIND_ERR = 2'd0;
   localparam logic [1:0] KIND_HDR = 2'd1;
   localparam logic [1:0] KIND_PAY = 2'd2;

   localparam logic [7:0]  ENTRY_BYTE    = 8'hE1;
   localparam logic [7:0]  TYPE_DCS_LONG = 8'h39;
   localparam logic [7:0]  TYPE_GEN_LONG = 8'h29;
   localparam logic [15:0] CRC_POLY      = 16'h8408;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;

   localparam logic [23:0] ECC_MASK [6] = '{
      24'hF12CB7, 24'hF2555B, 24'h749A6D, 24'hB8E38E, 24'hDF03F0, 24'hEFFC00
   };

   // beat positions within one command
   localparam logic [2:0] STEP_ENTRY  = 3'd0;
   localparam logic [2:0] STEP_TYPE   = 3'd1;
   localparam logic [2:0] STEP_WORD0  = 3'd2;
   localparam logic [2:0] STEP_WORD1  = 3'd3;
   localparam logic [2:0] STEP_TAIL   = 3'd4;
   localparam logic [2:0] STEP_CRC_LO = 3'd5;
   localparam logic [2:0] STEP_CRC_HI = 3'd6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_type;
      logic [7:0]  word0;
      logic [7:0]  word1;
      logic [7:0]  tail;
      logic        tail_last;
      logic        add_crc;
      logic [15:0] crc;
   } cmd_type;

   function automatic logic [7:0] flip8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7 - i] = v[i];
      end
      return r;
   endfunction

   function automatic logic [5:0] header_ecc(input logic [23:0] hdr);
      logic [5:0] e;
      for (int i = 0; i < 6; i++) begin
         e[i] = ^(hdr & ECC_MASK[i]);
      end
      return e;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ b[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/lpf_front.sv */
// Front end of the framer: accepts items, tracks packet state and CRC,
// and turns each item into one command for the back end.
// Depends on lpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpf_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [1:0]        func,
   input  wire logic [7:0]        data_type,
   input  wire logic [7:0]        word0,
   input  wire logic [7:0]        word1,
   input  wire logic              dcs_flag,
   input  wire logic [15:0]       word_count,
   input  wire logic [7:0]        payload_byte,
   input  wire logic              csr_write_enable,
   input  wire logic              csr_write_data,
   output lpf_pkg::cmd_type       cmd
);
   import lpf_pkg::*;

   logic        crc_enable_ff;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        packet_open_ff, packet_open_in;
   logic [15:0] crc_accum_ff, crc_accum_in;
   logic [15:0] crc_next;
   logic [15:0] bytes_dec;
   logic [7:0]  long_type;

   assign crc_next  = crc_byte(crc_accum_ff, payload_byte);
   assign bytes_dec = bytes_left_ff - 16'd1;
   assign long_type = dcs_flag ? TYPE_DCS_LONG : TYPE_GEN_LONG;

   always_comb begin
      cmd            = '0;
      cmd.kind       = KIND_ERR;
      cmd.tail_last  = 1'b1;
      bytes_left_in  = bytes_left_ff;
      packet_open_in = packet_open_ff;
      crc_accum_in   = crc_accum_ff;
      unique case (func)
         FUNC_SHORT: begin
            if (!packet_open_ff) begin
               cmd.kind      = KIND_HDR;
               cmd.data_type = data_type;
               cmd.word0     = word0;
               cmd.word1     = word1;
               cmd.tail      = {2'b00, header_ecc({word1, word0, data_type})};
               cmd.tail_last = 1'b1;
            end
         end
         FUNC_LONG: begin
            if (!packet_open_ff) begin
               cmd.kind      = KIND_HDR;
               cmd.data_type = long_type;
               cmd.word0     = word_count[7:0];
               cmd.word1     = word_count[15:8];
               cmd.tail      = {2'b00, header_ecc({word_count, long_type})};
               cmd.tail_last = 1'b0;
               crc_accum_in  = CRC_INIT;
               if (word_count == 16'd0) begin
                  cmd.add_crc = 1'b1;
                  cmd.crc     = crc_enable_ff ? CRC_INIT : 16'd0;
               end else begin
                  bytes_left_in  = word_count;
                  packet_open_in = 1'b1;
               end
            end
         end
         FUNC_PAYLOAD: begin
            if (packet_open_ff) begin
               cmd.kind      = KIND_PAY;
               cmd.tail      = payload_byte;
               cmd.tail_last = 1'b0;
               bytes_left_in = bytes_dec;
               if (bytes_dec == 16'd0) begin
                  cmd.add_crc    = 1'b1;
                  cmd.crc        = crc_enable_ff ? crc_next : 16'd0;
                  packet_open_in = 1'b0;
                  crc_accum_in   = CRC_INIT;
               end else begin
                  crc_accum_in = crc_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enable_ff  <= 1'b0;
         bytes_left_ff  <= '0;
         packet_open_ff <= 1'b0;
         crc_accum_ff   <= CRC_INIT;
      end else begin
         if (csr_write_enable) begin
            crc_enable_ff <= csr_write_data;
         end
         if (accept) begin
            bytes_left_ff  <= bytes_left_in;
            packet_open_ff <= packet_open_in;
            crc_accum_ff   <= crc_accum_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lpf_cmd_queue.sv */
// Short command queue between the framer front and back ends.
// Depends on lpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpf_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lpf_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output lpf_pkg::cmd_type      head_cmd,
   output logic                  empty
);
   import lpf_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]      count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/lpf_back.sv */
// Back end of the framer: steps through the head command and loads one
// output beat per cycle into the result register while it is empty or popped.
// Depends on lpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpf_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lpf_pkg::cmd_type head_cmd,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [7:0]            rsp_lp_byte,
   output logic                  rsp_last,
   output logic                  rsp_error
);
   import lpf_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff;
   logic       out_error_ff;
   logic       in_cmd_ff, in_cmd_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] cur_step, end_step;
   logic       emit;
   logic [7:0] beat_byte;
   logic       beat_last;

   assign cur_step = in_cmd_ff ? step_ff :
                     ((head_cmd.kind == KIND_HDR) ? STEP_ENTRY : STEP_TAIL);
   assign end_step = head_cmd.add_crc ? STEP_CRC_HI : STEP_TAIL;
   assign emit     = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop    = emit && (cur_step == end_step);

   always_comb begin
      beat_byte = '0;
      beat_last = 1'b0;
      unique case (cur_step)
         STEP_ENTRY:  beat_byte = ENTRY_BYTE;
         STEP_TYPE:   beat_byte = flip8(head_cmd.data_type);
         STEP_WORD0:  beat_byte = flip8(head_cmd.word0);
         STEP_WORD1:  beat_byte = flip8(head_cmd.word1);
         STEP_TAIL: begin
            beat_byte = flip8(head_cmd.tail);
            beat_last = head_cmd.tail_last;
         end
         STEP_CRC_LO: beat_byte = flip8(head_cmd.crc[7:0]);
         STEP_CRC_HI: begin
            beat_byte = flip8(head_cmd.crc[15:8]);
            beat_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      in_cmd_in    = in_cmd_ff;
      step_in      = step_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         if (cur_step == end_step) begin
            in_cmd_in = 1'b0;
         end else begin
            in_cmd_in = 1'b1;
            step_in   = cur_step + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff  <= beat_byte;
         out_last_ff  <= beat_last;
         out_error_ff <= (head_cmd.kind == KIND_ERR);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         in_cmd_ff    <= 1'b0;
         step_ff      <= STEP_ENTRY;
      end else begin
         out_valid_ff <= out_valid_in;
         in_cmd_ff    <= in_cmd_in;
         step_ff      <= step_in;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_lp_byte = out_byte_ff;
   assign rsp_last    = out_last_ff;
   assign rsp_error   = out_error_ff;

endmodule

`default_nettype wire

/* rtl/core/dsi_lp_packet_framer_top.sv */
// DSI low-power packet framer, top level.
// Instantiates lpf_front, lpf_cmd_queue and lpf_back; uses lpf_pkg.
//
// Usage: items enter on the req_ queue port (push while full is low) and
// framed bytes leave on the rsp_ queue port (pop while empty is low).
// A short packet item yields 5 beats, a long header 5 beats (7 when the
// word count is zero), a payload byte 1 beat (3 on the last byte, with the
// checksum), and a rejected item 1 error beat with last set.
// csr_write_enable/csr_write_data load crc_enable; write it only while idle.
// The first beat of an item passes through the command queue and then the
// result register. Throughput: one beat per cycle out of the back end while
// its result register is empty or popped; payload items are taken one per
// cycle while the queue has room. Header and checksum bursts are held in a
// 4-entry command queue, so the input stalls only once that queue fills.
// When rsp_pop stays low the result register holds its beat, the back end
// stops and the queue fills up, raising req_full. Reset empties the queue
// and output, closes any open packet and clears crc_enable.
`timescale 1ns / 1ps
`default_nettype none

module dsi_lp_packet_framer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_data_type,
   input  wire logic [7:0]  req_word0,
   input  wire logic [7:0]  req_word1,
   input  wire logic        req_dcs_flag,
   input  wire logic [15:0] req_word_count,
   input  wire logic [7:0]  req_payload_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_lp_byte,
   output logic             rsp_last,
   output logic             rsp_error,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data
);
   import lpf_pkg::*;

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    accept;
   logic    q_empty;
   logic    q_pop;

   assign accept = req_push && !req_full;

   lpf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .func             (req_func),
      .data_type        (req_data_type),
      .word0            (req_word0),
      .word1            (req_word1),
      .dcs_flag         (req_dcs_flag),
      .word_count       (req_word_count),
      .payload_byte     (req_payload_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (front_cmd)
   );

   lpf_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (front_cmd),
      .full     (req_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   lpf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_cmd    (head_cmd),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_lp_byte (rsp_lp_byte),
      .rsp_last    (rsp_last),
      .rsp_error   (rsp_error)
   );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for dsi_lp_packet_framer_top: directed table, then random packets.
// Predicts every framed byte beat, except that typed table rows give their own beat,
// and compares each popped beat in order. Depends on lpf_pkg and the framer RTL only.
`timescale 1ns / 1ps

module testbench;
   import lpf_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 107;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  data_type;
      logic [7:0]  word0;
      logic [7:0]  word1;
      logic        dcs_flag;
      logic [15:0] word_count;
      logic [7:0]  payload_byte;
   } framer_cmd_type;

   typedef struct packed {
      logic [7:0] lp_byte;
      logic       last;
      logic       error;
   } lp_beat_type;

   typedef struct packed {
      logic           crc_on;
      framer_cmd_type cmd;
      logic           typed;
      lp_beat_type    want;
   } dir_row_type;

   localparam lp_beat_type ERR_BEAT = '{8'h00, 1'b1, 1'b1};
   localparam lp_beat_type NO_BEAT  = '{8'h00, 1'b0, 1'b0};

   localparam int DIR_ROWS = 21;
   localparam dir_row_type DIR_TABLE [DIR_ROWS] = '{
      '{1'b0, '{FUNC_PAYLOAD, 8'h12, 8'h34, 8'h56, 1'b1, 16'h0003, 8'hFF}, 1'b1, ERR_BEAT},
      '{1'b0, '{FUNC_UNUSED,  8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 8'hFF}, 1'b1, ERR_BEAT},
      '{1'b0, '{FUNC_SHORT,   8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h00}, 1'b0, NO_BEAT},
      '{1'b0, '{FUNC_SHORT,   8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 8'hFF}, 1'b0, NO_BEAT},
      '{1'b0, '{FUNC_SHORT,   8'h05, 8'h36, 8'h00, 1'b1, 16'hA5A5, 8'h5A}, 1'b0, NO_BEAT},
      '{1'b0, '{FUNC_LONG,    8'hFF, 8'hFF, 8'hFF, 1'b1, 16'h0000, 8'hFF}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_LONG,    8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h00}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_LONG,    8'hFF, 8'hAA, 8'h55, 1'b1, 16'h0003, 8'hFF}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_SHORT,   8'h05, 8'h11, 8'h00, 1'b0, 16'h0000, 8'h00}, 1'b1, ERR_BEAT},
      '{1'b1, '{FUNC_LONG,    8'h00, 8'h00, 8'h00, 1'b1, 16'h0002, 8'h00}, 1'b1, ERR_BEAT},
      '{1'b1, '{FUNC_UNUSED,  8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h00}, 1'b1, ERR_BEAT},
      '{1'b1, '{FUNC_PAYLOAD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 8'h00}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'hFF}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_PAYLOAD, 8'h3C, 8'hC3, 8'h99, 1'b1, 16'h1234, 8'hA5}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_LONG,    8'h00, 8'h00, 8'h00, 1'b0, 16'h0002, 8'h00}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h3C}, 1'b0, NO_BEAT},
      '{1'b0, '{FUNC_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'hC3}, 1'b0, NO_BEAT},
      '{1'b0, '{FUNC_LONG,    8'h00, 8'h00, 8'h00, 1'b1, 16'h0001, 8'h00}, 1'b0, NO_BEAT},
      '{1'b0, '{FUNC_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h80}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_LONG,    8'h00, 8'h00, 8'h00, 1'b0, 16'h0001, 8'h00}, 1'b0, NO_BEAT},
      '{1'b1, '{FUNC_PAYLOAD, 8'h00, 8'h00, 8'h00, 1'b0, 16'h0000, 8'h01}, 1'b0, NO_BEAT}
   };

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_func;
   logic [7:0]  req_data_type;
   logic [7:0]  req_word0;
   logic [7:0]  req_word1;
   logic        req_dcs_flag;
   logic [15:0] req_word_count;
   logic [7:0]  req_payload_byte;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_lp_byte;
   logic        rsp_last;
   logic        rsp_error;
   logic        csr_write_enable;
   logic        csr_write_data;

   // framer state as seen by the predictor
   logic        crc_on;
   logic        pkt_open;
   logic [15:0] pay_left;
   logic [15:0] crc_run;

   lp_beat_type lp_expect [$];
   lp_beat_type burst_q [$];
   lp_beat_type want_beat;
   int          send_gap_pct;
   int          pop_stall_pct;
   int          mismatches;
   int          cycles;

   dsi_lp_packet_framer_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_data_type    (req_data_type),
      .req_word0        (req_word0),
      .req_word1        (req_word1),
      .req_dcs_flag     (req_dcs_flag),
      .req_word_count   (req_word_count),
      .req_payload_byte (req_payload_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_lp_byte      (rsp_lp_byte),
      .rsp_last         (rsp_last),
      .rsp_error        (rsp_error),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7 - i];
      end
      return r;
   endfunction

   function automatic logic [5:0] ecc6(input logic [23:0] h);
      return {^(h & 24'hEFFC00), ^(h & 24'hDF03F0), ^(h & 24'hB8E38E),
              ^(h & 24'h749A6D), ^(h & 24'hF2555B), ^(h & 24'hF12CB7)};
   endfunction

   function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         r = (r[0] ^ b[i]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

   function automatic framer_cmd_type rand_cmd(input logic [1:0] f);
      framer_cmd_type c;
      c.func = f;
      c.data_type = 8'($urandom);
      c.word0 = 8'($urandom);
      c.word1 = 8'($urandom);
      c.dcs_flag = 1'($urandom);
      c.word_count = 16'($urandom);
      c.payload_byte = 8'($urandom);
      return c;
   endfunction

   task automatic add_beat(input logic [7:0] b, input logic l, input logic e);
      burst_q.push_back('{b, l, e});
   endtask

   task automatic add_header(input logic [7:0] dt, input logic [7:0] w0, input logic [7:0] w1,
                             input logic l);
      add_beat(ENTRY_BYTE, 1'b0, 1'b0);
      add_beat(rev8(dt), 1'b0, 1'b0);
      add_beat(rev8(w0), 1'b0, 1'b0);
      add_beat(rev8(w1), 1'b0, 1'b0);
      add_beat(rev8({2'b00, ecc6({w1, w0, dt})}), l, 1'b0);
   endtask

   task automatic add_checksum();
      logic [15:0] sum;
      sum = crc_on ? crc_run : 16'h0000;
      add_beat(rev8(sum[7:0]), 1'b0, 1'b0);
      add_beat(rev8(sum[15:8]), 1'b1, 1'b0);
   endtask

   task automatic frame_cmd(input framer_cmd_type c);
      case (c.func)
         FUNC_SHORT: begin
            if (pkt_open) add_beat(8'h00, 1'b1, 1'b1);
            else add_header(c.data_type, c.word0, c.word1, 1'b1);
         end
         FUNC_LONG: begin
            if (pkt_open) begin
               add_beat(8'h00, 1'b1, 1'b1);
            end else begin
               add_header(c.dcs_flag ? TYPE_DCS_LONG : TYPE_GEN_LONG,
                          c.word_count[7:0], c.word_count[15:8], 1'b0);
               crc_run = CRC_INIT;
               if (c.word_count == 16'h0000) begin
                  add_checksum();
               end else begin
                  pay_left = c.word_count;
                  pkt_open = 1'b1;
               end
            end
         end
         FUNC_PAYLOAD: begin
            if (!pkt_open) begin
               add_beat(8'h00, 1'b1, 1'b1);
            end else begin
               add_beat(rev8(c.payload_byte), 1'b0, 1'b0);
               crc_run = crc16_step(crc_run, c.payload_byte);
               pay_left = pay_left - 16'd1;
               if (pay_left == 16'h0000) begin
                  add_checksum();
                  pkt_open = 1'b0;
                  crc_run = CRC_INIT;
               end
            end
         end
         default: add_beat(8'h00, 1'b1, 1'b1);
      endcase
   endtask

   task automatic send_cmd(input framer_cmd_type c, input logic typed, input lp_beat_type want);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_func = c.func;
      req_data_type = c.data_type;
      req_word0 = c.word0;
      req_word1 = c.word1;
      req_dcs_flag = c.dcs_flag;
      req_word_count = c.word_count;
      req_payload_byte = c.payload_byte;
      req_push = 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      burst_q.delete();
      frame_cmd(c);
      if (typed) begin
         lp_expect.push_back(want);
      end else begin
         foreach (burst_q[k]) lp_expect.push_back(burst_q[k]);
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_push = 1'b0;
      while (lp_expect.size() != 0) @(negedge clock);
   endtask

   task automatic write_crc_enable(input logic v);
      wait_drained();
      csr_write_enable = 1'b1;
      csr_write_data = v;
      @(negedge clock);
      csr_write_enable = 1'b0;
      crc_on = v;
   endtask

   task automatic random_phase(input int n);
      int             sent;
      int             pick;
      logic [15:0]    wc;
      framer_cmd_type c;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(49) == 0) wait_drained();
         pick = $urandom_range(99);
         if (pick < 65) begin
            pick = $urandom_range(99);
            if (pick < 25) wc = 16'd0;
            else if (pick < 85) wc = 16'($urandom_range(8, 1));
            else if (pick < 98) wc = 16'($urandom_range(40, 9));
            else wc = 16'($urandom_range(300, 150));
            // keep the phase near its item budget
            if (int'(wc) > n - sent - 1) wc = 16'(n - sent - 1);
            c = rand_cmd(FUNC_LONG);
            c.word_count = wc;
            send_cmd(c, 1'b0, NO_BEAT);
            sent++;
            for (int j = 0; j < wc; j++) begin
               if ($urandom_range(19) == 0) begin
                  pick = $urandom_range(2);
                  c = rand_cmd(pick == 0 ? FUNC_SHORT : (pick == 1 ? FUNC_LONG : FUNC_UNUSED));
                  send_cmd(c, 1'b0, NO_BEAT);
                  sent++;
               end
               send_cmd(rand_cmd(FUNC_PAYLOAD), 1'b0, NO_BEAT);
               sent++;
            end
         end else if (pick < 88) begin
            send_cmd(rand_cmd(FUNC_SHORT), 1'b0, NO_BEAT);
            sent++;
         end else begin
            send_cmd(rand_cmd($urandom_range(1) ? FUNC_PAYLOAD : FUNC_UNUSED), 1'b0, NO_BEAT);
            sent++;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (lp_expect.size() == 0) begin
            $display("%0t: unexpected beat lp_byte %02h last %0d error %0d",
                     $time, rsp_lp_byte, rsp_last, rsp_error);
            mismatches++;
         end else begin
            want_beat = lp_expect.pop_front();
            if (rsp_lp_byte !== want_beat.lp_byte) begin
               $display("%0t: lp_byte expected %02h actual %02h",
                        $time, want_beat.lp_byte, rsp_lp_byte);
               mismatches++;
            end
            if (rsp_last !== want_beat.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want_beat.last, rsp_last);
               mismatches++;
            end
            if (rsp_error !== want_beat.error) begin
               $display("%0t: error expected %0d actual %0d", $time, want_beat.error, rsp_error);
               mismatches++;
            end
         end
      end
   end

   initial begin
      framer_cmd_type c;
      reset = 1'b1;
      req_push = 1'b0;
      req_func = FUNC_SHORT;
      req_data_type = 8'h00;
      req_word0 = 8'h00;
      req_word1 = 8'h00;
      req_dcs_flag = 1'b0;
      req_word_count = 16'h0000;
      req_payload_byte = 8'h00;
      csr_write_enable = 1'b0;
      csr_write_data = 1'b0;
      crc_on = 1'b0;
      pkt_open = 1'b0;
      pay_left = 16'h0000;
      crc_run = CRC_INIT;
      mismatches = 0;
      cycles = 0;
      send_gap_pct = 11;
      pop_stall_pct = 73;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (DIR_TABLE[r].crc_on != crc_on) write_crc_enable(DIR_TABLE[r].crc_on);
         send_cmd(DIR_TABLE[r].cmd, DIR_TABLE[r].typed, DIR_TABLE[r].want);
      end

      write_crc_enable(1'b1);
      random_phase(PHASE_ITEMS);

      write_crc_enable(1'b0);
      send_gap_pct = 73;
      pop_stall_pct = 11;
      random_phase(PHASE_ITEMS);

      write_crc_enable(1'b1);
      send_gap_pct = 0;
      pop_stall_pct = 0;
      random_phase(PHASE_ITEMS);

      // largest word count in the header, followed by four payload beats
      c = rand_cmd(FUNC_LONG);
      c.word_count = 16'hFFFF;
      send_cmd(c, 1'b0, NO_BEAT);
      for (int j = 0; j < 4; j++) begin
         send_cmd(rand_cmd(FUNC_PAYLOAD), 1'b0, NO_BEAT);
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/lpf_pkg.sv
rtl/core/lpf_front.sv
rtl/core/lpf_cmd_queue.sv
rtl/core/lpf_back.sv
rtl/core/dsi_lp_packet_framer_top.sv
tb/sv/testbench.sv
